/* src/pwa_pkg.sv */
// shared types, register codes and reset values for the pulse width averager
`timescale 1ns / 1ps

package pwa_pkg;

	localparam int WIDTH_W       = 16;
	localparam int TIME_W        = 32;
	localparam int CFG_IDX_W     = 2;
	localparam int DEPTH_DEFAULT = 8;

	// register indexes on the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DEFAULT_WIDTH = 2'd2;

	// reset values of the registers
	localparam logic [WIDTH_W-1:0] MIN_WIDTH_RST     = 16'd1000;
	localparam logic [WIDTH_W-1:0] MAX_WIDTH_RST     = 16'd2000;
	localparam logic [WIDTH_W-1:0] DEFAULT_WIDTH_RST = 16'd1500;

	// action codes
	localparam logic ACTION_PIN    = 1'b0;
	localparam logic ACTION_PRESET = 1'b1;

	typedef struct packed {
		logic              action;
		logic              pin_level;
		logic [TIME_W-1:0] time_us;
	} in_item_t;

	typedef struct packed {
		logic [WIDTH_W-1:0] average_width;
		logic               width_accepted;
	} out_item_t;

	typedef struct packed {
		logic [WIDTH_W-1:0] min_width;
		logic [WIDTH_W-1:0] max_width;
		logic [WIDTH_W-1:0] default_width;
	} cfg_t;

endpackage

/* src/pwa_cfg_regs.sv */
// configuration register bank of the pulse width averager
`timescale 1ns / 1ps

module pwa_cfg_regs import pwa_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WIDTH_W-1:0]   cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.min_width     <= MIN_WIDTH_RST;
			cfg_q.max_width     <= MAX_WIDTH_RST;
			cfg_q.default_width <= DEFAULT_WIDTH_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_MIN_WIDTH:     cfg_q.min_width     <= cfg_data;
				CFG_MAX_WIDTH:     cfg_q.max_width     <= cfg_data;
				CFG_DEFAULT_WIDTH: cfg_q.default_width <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* src/pwa_core.sv */
// edge detection, width ring and running total of the pulse width averager
`timescale 1ns / 1ps

module pwa_core import pwa_pkg::*; #(
	parameter  int DEPTH = DEPTH_DEFAULT,
	localparam int LOG   = $clog2(DEPTH),
	localparam int TW    = WIDTH_W + LOG
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          step,
	input  in_item_t      item,
	input  cfg_t          cfg,
	output logic [TW-1:0] nxt_total,
	output logic          accepted
);

	localparam logic [LOG-1:0] SLOT_LAST = LOG'(DEPTH - 1);
	localparam logic [TW-1:0]  TOTAL_RST = TW'(DEPTH) * TW'(DEFAULT_WIDTH_RST);

	logic               last_level_q;
	logic [TIME_W-1:0]  rise_time_q;
	logic [LOG-1:0]     slot_q;
	logic [TW-1:0]      total_q;
	logic [WIDTH_W-1:0] fill_q;
	logic [DEPTH-1:0]   valid_q;
	logic [WIDTH_W-1:0] ring_mem [DEPTH];
	logic [WIDTH_W-1:0] rd_q;

	logic               is_preset;
	logic               is_edge;
	logic [TIME_W-1:0]  width_full;
	logic [WIDTH_W-1:0] width;
	logic               in_range;
	logic [WIDTH_W-1:0] old_width;
	logic [LOG-1:0]     slot_inc;
	logic [LOG-1:0]     slot_d;
	logic               wr_en;

	always_comb begin
		is_preset  = (item.action == ACTION_PRESET);
		is_edge    = (item.action == ACTION_PIN) && (item.pin_level != last_level_q);
		width_full = item.time_us - rise_time_q;
		width      = width_full[WIDTH_W-1:0];
		in_range   = (width_full >= TIME_W'(cfg.min_width)) &&
		             (width_full <= TIME_W'(cfg.max_width));
		accepted   = is_edge && !item.pin_level && in_range;
		// entries not written since the last preset hold the fill value
		old_width  = valid_q[slot_q] ? rd_q : fill_q;
		slot_inc   = (slot_q == SLOT_LAST) ? '0 : slot_q + LOG'(1);
		wr_en      = step && accepted;
		slot_d     = wr_en ? slot_inc : slot_q;
		if (is_preset) begin
			nxt_total = TW'(cfg.default_width) * TW'(DEPTH);
		end else if (accepted) begin
			nxt_total = total_q - TW'(old_width) + TW'(width);
		end else begin
			nxt_total = total_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_level_q <= 1'b0;
			rise_time_q  <= '0;
			slot_q       <= '0;
			total_q      <= TOTAL_RST;
			fill_q       <= DEFAULT_WIDTH_RST;
			valid_q      <= '0;
		end else if (step) begin
			total_q <= nxt_total;
			slot_q  <= slot_d;
			if (is_preset) begin
				fill_q  <= cfg.default_width;
				valid_q <= '0;
			end else if (is_edge) begin
				last_level_q <= item.pin_level;
				if (item.pin_level) begin
					rise_time_q <= item.time_us;
				end
				if (accepted) begin
					valid_q[slot_q] <= 1'b1;
				end
			end
		end
	end

	// prefetch the entry the next accepted width will replace
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem[slot_q] <= width;
		end
		rd_q <= ring_mem[slot_d];
	end

endmodule

/* src/pwa_mean_div.sv */
// divides the ring total by the depth through a reciprocal multiply
`timescale 1ns / 1ps

module pwa_mean_div import pwa_pkg::*; #(
	parameter  int DEPTH = DEPTH_DEFAULT,
	localparam int LOG   = $clog2(DEPTH),
	localparam int TW    = WIDTH_W + LOG
) (
	input  logic [TW-1:0]      total,
	output logic [WIDTH_W-1:0] mean
);

	// ceil(2^SHIFT / DEPTH) gives an exact floor quotient for any TW-bit total
	localparam int SHIFT = TW + LOG;
	localparam int PW    = TW + TW + 1;
	localparam longint unsigned RECIP =
		((longint'(1) << SHIFT) + longint'(DEPTH) - 1) / longint'(DEPTH);

	logic [PW-1:0] prod;

	assign prod = PW'(total) * PW'(RECIP);
	assign mean = prod[SHIFT +: WIDTH_W];

endmodule

/* src/pulse_width_averager_unit.sv */
// top level of the pulse width averager
`timescale 1ns / 1ps

// Measures high pulses from pin-change transactions and reports a moving mean
// of the last DEPTH accepted widths. Each transaction carries an action, the
// pin level and a 32-bit microsecond timestamp; a repeated level is ignored,
// a rising level stores the start time and a falling level yields the width
// (timestamp difference modulo 2^32). A width inside [min_width, max_width]
// replaces the oldest ring entry. The preset action loads default_width into
// every entry at once. Every input transaction gives exactly one output
// transaction: the truncated ring mean plus a flag telling whether a width
// was stored. One transaction is taken per clock while the output is not
// stalled. There are three register stages (input register, ring update,
// divide by DEPTH through a reciprocal multiply into the output register);
// a stall on the output holds the full stages. The registers are written
// through cfg_wr_en/cfg_index/cfg_data; the user must do so only while no
// transaction is in flight, and the block itself does not enforce this;
// index 3 is ignored. The ring needs no clearing after reset.
module pulse_width_averager_unit import pwa_pkg::*; #(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input channel
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	// output channel
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	// configuration writes
	input  logic                 cfg_wr_en,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WIDTH_W-1:0]   cfg_data
);

	localparam int LOG = $clog2(DEPTH);
	localparam int TW  = WIDTH_W + LOG;

	cfg_t cfg;

	// stage 1: registered input transaction
	logic     valid_s1;
	in_item_t item_s1;

	// stage 2: ring total after the transaction and its accept flag
	logic          valid_s2;
	logic [TW-1:0] total_s2;
	logic          acc_s2;

	// stage 3: output register
	logic      valid_s3;
	out_item_t data_s3;

	logic               ready_s3;
	logic               ready_s2;
	logic               ready_s1;
	logic               step;
	logic [TW-1:0]      nxt_total;
	logic               core_accepted;
	logic [WIDTH_W-1:0] mean;

	// a stage moves when it is empty or the stage after it moves
	assign ready_s3 = !valid_s3 || !out_stall;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign in_stall = !ready_s1;

	// the ring state advances when the stage 1 transaction moves on
	assign step = valid_s1 && ready_s2;

	pwa_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pwa_core #(.DEPTH(DEPTH)) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.item      (item_s1),
		.cfg       (cfg),
		.nxt_total (nxt_total),
		.accepted  (core_accepted)
	);

	pwa_mean_div #(.DEPTH(DEPTH)) u_div (
		.total (total_s2),
		.mean  (mean)
	);

	// valid bits of the pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) begin
				valid_s1 <= in_valid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
			if (ready_s3) begin
				valid_s3 <= valid_s2;
			end
		end
	end

	// payload registers load only when a transaction enters the stage
	always_ff @(posedge clk) begin
		if (in_valid && ready_s1) begin
			item_s1 <= in_data;
		end
		if (step) begin
			total_s2 <= nxt_total;
			acc_s2   <= core_accepted;
		end
		if (valid_s2 && ready_s3) begin
			data_s3.average_width  <= mean;
			data_s3.width_accepted <= acc_s2;
		end
	end

	assign out_valid = valid_s3;
	assign out_data  = data_s3;

	// the input is held off only when every stage holds a transaction
	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && valid_s2 && valid_s3))
		else $error("input stalled with a free pipeline stage");

	// a preset never reports a stored width
	a_preset_not_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		(step && item_s1.action == ACTION_PRESET) |=> !acc_s2)
		else $error("preset transaction flagged as accepted");

	// a stored width always comes from a falling pin event
	a_accept_on_fall: assert property (@(posedge clk) disable iff (!arst_n)
		(step && core_accepted) |-> (item_s1.action == ACTION_PIN && !item_s1.pin_level))
		else $error("width accepted without a falling pin event");

endmodule
